// ----- rtl/itoa_pkg.sv -----
// Package for the integer to ASCII converter: widths, opcodes, stage types.
// No dependencies.
package itoa_pkg;
  localparam int unsigned ValueWidth = 64;
  localparam int unsigned NumDigits  = 20;
  localparam int unsigned BcdWidth   = NumDigits * 4;
  localparam int unsigned CntWidth   = $clog2(NumDigits + 2);
  localparam int unsigned BitsPerStg = 8;
  localparam int unsigned NumStages  = ValueWidth / BitsPerStg;

  typedef enum logic [1:0] {
    OP_UDEC = 2'd0,
    OP_SDEC = 2'd1,
    OP_HEXL = 2'd2,
    OP_HEXU = 2'd3
  } op_t;

  // one word moving down the double-dabble pipeline
  typedef struct packed {
    logic                  vld;
    logic                  hex;
    logic                  upper;
    logic                  neg;
    logic [ValueWidth-1:0] bin;
    logic [BcdWidth-1:0]   bcd;
  } stg_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'd0, d};
    else if (upper) c = 8'h41 + {4'd0, d} - 8'd10;
    else c = 8'h61 + {4'd0, d} - 8'd10;
    return c;
  endfunction
endpackage

// ----- rtl/itoa_dabble.sv -----
// One double-dabble stage: shifts BitsPerStg binary bits into the BCD word; in hex mode the BCD word is left as it is.
// Depends on itoa_pkg.
module itoa_dabble (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  itoa_pkg::stg_t d_in,
  output itoa_pkg::stg_t d_out
);
  import itoa_pkg::*;

  stg_t q_r;
  stg_t q_nxt;
  logic [BcdWidth-1:0]   b;
  logic [ValueWidth-1:0] v;

  always_comb begin
    b = d_in.bcd;
    v = d_in.bin;
    for (int s = 0; s < BitsPerStg; s++) begin
      for (int k = 0; k < NumDigits; k++) begin
        if (b[k*4 +: 4] >= 4'd5) b[k*4 +: 4] = b[k*4 +: 4] + 4'd3;
      end
      b = {b[BcdWidth-2:0], v[ValueWidth-1]};
      v = {v[ValueWidth-2:0], 1'b0};
    end
    q_nxt     = d_in;
    q_nxt.bin = v;
    if (!d_in.hex) q_nxt.bcd = b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q_r.vld <= 1'b0;
    else if (adv) q_r.vld <= d_in.vld;
    if (adv) begin
      q_r.hex <= q_nxt.hex; q_r.upper <= q_nxt.upper; q_r.neg <= q_nxt.neg;
      q_r.bin <= q_nxt.bin; q_r.bcd <= q_nxt.bcd;
    end
  end

  assign d_out = q_r;
endmodule

// ----- rtl/itoa_emit.sv -----
// Character sequencer: strips leading zeros and emits sign and digits.
// Depends on itoa_pkg.
module itoa_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  itoa_pkg::stg_t d_in,
  input  logic [63:0]    hex_val,
  output logic           take,
  output logic           busy_o,
  output logic           strobe,
  output logic [7:0]     chr,
  output logic           lst
);
  import itoa_pkg::*;

  logic                  act_r;
  logic [BcdWidth-1:0]   dig_r;
  logic [CntWidth-1:0]   cnt_r;
  logic                  sgn_r;
  logic                  up_r;
  logic                  str_r;
  logic [7:0]            chr_r;
  logic                  lst_r;
  logic [BcdWidth-1:0]   src;
  logic [CntWidth-1:0]   nd;

  always_comb begin
    src = d_in.hex ? {16'd0, hex_val} : d_in.bcd;
    nd  = CntWidth'(1);
    for (int k = 1; k < NumDigits; k++) begin
      if (src[k*4 +: 4] != 4'd0) nd = CntWidth'(k + 1);
    end
  end

  assign take   = d_in.vld && !act_r;
  assign busy_o = act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      str_r <= 1'b0;
    end else if (take) begin
      act_r <= 1'b1;
      str_r <= 1'b0;
      // left-align the top digit
      dig_r <= src << ((NumDigits - 32'(nd)) * 4);
      cnt_r <= nd;
      sgn_r <= d_in.neg;
      up_r  <= d_in.upper;
    end else if (act_r) begin
      str_r <= 1'b1;
      if (sgn_r) begin
        chr_r <= 8'h2D;
        lst_r <= 1'b0;
        sgn_r <= 1'b0;
      end else begin
        chr_r <= digit_char(dig_r[BcdWidth-1 -: 4], up_r);
        lst_r <= (cnt_r == CntWidth'(1));
        dig_r <= dig_r << 4;
        cnt_r <= cnt_r - CntWidth'(1);
        if (cnt_r == CntWidth'(1)) act_r <= 1'b0;
      end
    end else begin
      str_r <= 1'b0;
    end
  end

  assign strobe = str_r;
  assign chr    = chr_r;
  assign lst    = lst_r;

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r && !sgn_r && cnt_r == CntWidth'(1)) |=> (str_r && lst_r && !act_r))
    else $error("last digit not flagged");
  a_no_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!act_r && !$past(act_r)) |-> !str_r)
    else $error("strobe while idle");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> (cnt_r != CntWidth'(0)))
    else $error("digit count zero while active");
endmodule

// ----- rtl/integer_to_ascii_digits.sv -----
// Integer to ASCII: 8-stage double-dabble pipeline then a character sequencer.
// One character per cycle once the sequencer has started on a number.
// A number gives up to 20 characters. The sequencer takes a new word only when idle; the
// pipeline stalls, with busy high, while the last stage holds a word it cannot take.
// Reset: synchronous active-low rst_n clears all valid bits and the sequencer.
// Depends on itoa_pkg, itoa_dabble, itoa_emit.
module integer_to_ascii_digits (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value,
  input  logic [1:0]  in_opcode,
  output logic        out_strobe,
  output logic [7:0]  out_character,
  output logic        out_last
);
  import itoa_pkg::*;

  stg_t st [NumStages+1];
  stg_t in_r;
  logic take, eb, adv, hold;
  op_t  op;

  assign op = op_t'(in_opcode);

  // pipeline advances unless the last stage holds a word the sequencer refuses
  assign hold = st[NumStages].vld && !take;
  assign adv  = !hold;
  assign busy = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) in_r.vld <= 1'b0;
    else if (adv) in_r.vld <= start;
    if (adv) begin
      in_r.hex   <= (op == OP_HEXL) || (op == OP_HEXU);
      in_r.upper <= (op == OP_HEXU);
      in_r.neg   <= (op == OP_SDEC) && in_value[ValueWidth-1];
      in_r.bin   <= ((op == OP_SDEC) && in_value[ValueWidth-1]) ? (~in_value + 64'd1)
                                                                 : in_value;
      in_r.bcd   <= '0;
    end
  end

  assign st[0] = in_r;

  for (genvar g = 0; g < NumStages; g++) begin : g_stg
    itoa_dabble u_stg (.clk(clk), .rst_n(rst_n), .adv(adv), .d_in(st[g]),
                       .d_out(st[g+1]));
  end

  // hex digits come straight from the original bits, which the stages shift out
  logic [63:0] hex_r [NumStages+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      hex_r[0] <= in_value;
      for (int k = 0; k < NumStages; k++) hex_r[k+1] <= hex_r[k];
    end
  end

  itoa_emit u_emit (.clk(clk), .rst_n(rst_n), .d_in(st[NumStages]),
                    .hex_val(hex_r[NumStages]), .take(take), .busy_o(eb),
                    .strobe(out_strobe), .chr(out_character), .lst(out_last));

  a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && st[NumStages].vld) |=> st[NumStages].vld)
    else $error("held word dropped");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> !eb)
    else $error("word taken while sequencer active");
  a_strobe_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(eb))
    else $error("strobe without active sequencer");
endmodule
